// ----- rtl/core/pfsr_pkg.sv -----
`default_nettype none

package pfsr_pkg;

  // Operation codes carried on in_op
  typedef enum logic [2:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_FIND   = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_HEAD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SH_RD,
    S_SH_WR,
    S_FIN
  } ctrl_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic    load;      // capture the incoming word
    logic    wr_enq;    // write the captured entry at the tail, count up
    logic    rd_cur;    // read logical slot idx
    logic    rd_nxt;    // read logical slot idx+1
    logic    wr_shift;  // write the last read entry to logical slot idx
    logic    idx_inc;
    logic    pop;       // drop the head entry: head up, count down
    logic    cnt_dec;   // drop the tail entry
    logic    res_set;
    status_t res_code;
    logic    res_data;  // result takes name/ref from the last read entry
    logic    out_load;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       full;
    logic       match;     // last read entry matches the key
    logic       idx_zero;
    logic       idx_last;  // idx is the tail slot
    logic       idx_pen;   // idx is the slot before the tail
  } stat_t;

  // Matching form of a name: bytes kept up to the first zero byte,
  // and only within the low nbytes bytes.
  function automatic logic [63:0] name_key(input logic [63:0] n, input int unsigned nbytes);
    logic [63:0] k;
    logic        live;
    k    = '0;
    live = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (b >= nbytes) live = 1'b0;
      if (n[8*b +: 8] == 8'h00) live = 1'b0;
      if (live) k[8*b +: 8] = n[8*b +: 8];
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pfsr_ram.sv -----
`default_nettype none

module pfsr_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/pfsr_dpath.sv -----
`default_nettype none

module pfsr_dpath
  import pfsr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int NAME_BYTES  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [2:0]  in_op,
  input  wire logic [63:0] in_proc_name,
  input  wire logic [15:0] in_proc_ref,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  output logic [1:0]       out_status,
  output logic [63:0]      out_name,
  output logic [15:0]      out_ref,
  output logic [4:0]       out_fill_count,
  output logic             out_is_empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NB = 8 * NAME_BYTES;
  localparam int EW = NB + 16;

  logic [2:0]    op_r;
  logic [63:0]   key_r;
  logic [NB-1:0] name_r;
  logic [15:0]   ref_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r;
  status_t       res_status_r;
  logic [NB-1:0] res_name_r;
  logic [15:0]   res_ref_r;
  status_t       out_status_r;
  logic [NB-1:0] out_name_r;
  logic [15:0]   out_ref_r;
  logic [4:0]    out_fill_r;
  logic          out_empty_r;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, rd_data;
  logic [NB-1:0] rd_name;
  logic [15:0]   rd_ref;
  logic [AW-1:0] phys_enq, phys_cur, phys_nxt, head_inc;
  logic [CW+4:0] cnt_ext;

  // Ring index: the sum stays below twice the depth
  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] t;
    t = (s >= (AW+1)'(QUEUE_DEPTH)) ? s - (AW+1)'(QUEUE_DEPTH) : s;
    return t[AW-1:0];
  endfunction

  assign rd_name = rd_data[EW-1:16];
  assign rd_ref  = rd_data[15:0];

  always_comb begin
    phys_enq = wrap({1'b0, head_r} + {1'b0, count_r[AW-1:0]});
    phys_cur = wrap({1'b0, head_r} + {1'b0, idx_r});
    phys_nxt = wrap({1'b0, head_r} + {1'b0, idx_r} + (AW+1)'(1));
    head_inc = wrap({1'b0, head_r} + (AW+1)'(1));
  end

  assign wr_en   = cmd.wr_enq | cmd.wr_shift;
  assign wr_addr = cmd.wr_enq ? phys_enq : phys_cur;
  assign wr_data = cmd.wr_enq ? {name_r, ref_r} : rd_data;
  assign rd_en   = cmd.rd_cur | cmd.rd_nxt;
  assign rd_addr = cmd.rd_nxt ? phys_nxt : phys_cur;

  pfsr_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    stat.op       = op_r;
    stat.empty    = (count_r == '0);
    stat.full     = (count_r == CW'(QUEUE_DEPTH));
    stat.match    = (name_key(64'(rd_name), NAME_BYTES) == key_r);
    stat.idx_zero = (idx_r == '0);
    stat.idx_last = (CW'(idx_r) + CW'(1) == count_r);
    stat.idx_pen  = (CW'(idx_r) + CW'(2) == count_r);
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.wr_enq) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop) begin
      head_nxt  = head_inc;
      count_nxt = count_r - CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  assign cnt_ext = {5'b0, count_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      key_r  <= name_key(in_proc_name, NAME_BYTES);
      name_r <= in_proc_name[NB-1:0];
      ref_r  <= in_proc_ref;
      idx_r  <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
      res_name_r   <= cmd.res_data ? rd_name : '0;
      res_ref_r    <= cmd.res_data ? rd_ref : '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_name_r   <= res_name_r;
      out_ref_r    <= res_ref_r;
      out_fill_r   <= cnt_ext[4:0];
      out_empty_r  <= (count_r == '0);
    end
  end

  assign out_status     = out_status_r;
  assign out_name       = 64'(out_name_r);
  assign out_ref        = out_ref_r;
  assign out_fill_count = out_fill_r;
  assign out_is_empty   = out_empty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_enq_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_enq |-> !stat.full)
    else $error("enqueue write into a full queue");

  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop || cmd.cnt_dec) |-> !stat.empty)
    else $error("entry dropped from an empty queue");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> count_r == $past(count_r) - CW'(1))
    else $error("head drop did not reduce the count by one");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_enq, cmd.wr_shift}))
    else $error("two writes to the entry store in one cycle");

endmodule

`default_nettype wire

// ----- rtl/core/pfsr_ctrl.sv -----
`default_nettype none

module pfsr_ctrl
  import pfsr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_DEQ, OP_PEEK:    state_nxt = stat.empty ? S_FIN : S_HEAD;
          OP_FIND, OP_REMOVE: state_nxt = stat.empty ? S_FIN : S_SCAN_CMP;
          default:            state_nxt = S_FIN;
        endcase
      end
      S_HEAD:    state_nxt = S_FIN;
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (stat.match) begin
          if (stat.op == OP_REMOVE && !stat.idx_last && !stat.idx_zero) begin
            state_nxt = S_SH_RD;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (stat.idx_last) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SH_RD: state_nxt = S_SH_WR;
      S_SH_WR: state_nxt = stat.idx_pen ? S_FIN : S_SH_RD;
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.res_code = ST_MISS;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_ENQ: begin
            cmd.res_set = 1'b1;
            if (stat.full) begin
              cmd.res_code = ST_FULL;
            end else begin
              cmd.wr_enq   = 1'b1;
              cmd.res_code = ST_OK;
            end
          end
          OP_DEQ, OP_PEEK, OP_FIND, OP_REMOVE: begin
            if (stat.empty) cmd.res_set = 1'b1;
            else cmd.rd_cur = 1'b1;
          end
          default: cmd.res_set = 1'b1;
        endcase
      end
      S_HEAD: begin
        cmd.res_set  = 1'b1;
        cmd.res_code = ST_OK;
        cmd.res_data = 1'b1;
        cmd.pop      = (stat.op == OP_DEQ);
      end
      S_SCAN_RD: begin
        cmd.rd_cur = 1'b1;
      end
      S_SCAN_CMP: begin
        if (stat.match) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OK;
          cmd.res_data = 1'b1;
          if (stat.op == OP_REMOVE) begin
            if (stat.idx_last) cmd.cnt_dec = 1'b1;
            else if (stat.idx_zero) cmd.pop = 1'b1;
          end
        end else if (stat.idx_last) begin
          cmd.res_set = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SH_RD: begin
        cmd.rd_nxt = 1'b1;
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        if (stat.idx_pen) cmd.cnt_dec = 1'b1;
        else cmd.idx_inc = 1'b1;
      end
      S_FIN: begin
        cmd.out_load = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/process_fifo_with_search_remove.sv -----
`default_nettype none

// Channel   Handshake               Payload
// in_       in_valid / in_ready     in_op, in_proc_name, in_proc_ref
// out_      out_valid / out_ready   out_status, out_name, out_ref,
//                                   out_fill_count, out_is_empty
//
// One word at a time. Enqueue, empty-queue misses and unused codes go from decode straight
// to the finish step, dequeue and peek through a head step first; in_ready rises with out_valid.
// Find and remove read and then compare each entry in turn (one registered read port);
// a remove from the middle then reads and rewrites each later entry to close the gap.
// Reset (rst_n low, synchronous) empties the queue; stored entries are not cleared.
// A result stalled on out_ready holds the following word in its last step.

module process_fifo_with_search_remove
  import pfsr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int NAME_BYTES  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [63:0] in_proc_name,
  input  wire logic [15:0] in_proc_ref,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [63:0]      out_name,
  output logic [15:0]      out_ref,
  output logic [4:0]       out_fill_count,
  output logic             out_is_empty
);

  // Controller sequences each operation; the datapath holds the ring of
  // entries (head pointer + count), the scan index and the result registers.
  cmd_t  cmd;
  stat_t stat;

  pfsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfsr_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NAME_BYTES  (NAME_BYTES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_op          (in_op),
    .in_proc_name   (in_proc_name),
    .in_proc_ref    (in_proc_ref),
    .cmd            (cmd),
    .stat           (stat),
    .out_status     (out_status),
    .out_name       (out_name),
    .out_ref        (out_ref),
    .out_fill_count (out_fill_count),
    .out_is_empty   (out_is_empty)
  );

endmodule

`default_nettype wire
